// ----- rtl/core/ptnf_pkg.sv -----
// ptnf_pkg: shared types, constants and the row scale table for pitch_to_note_fine.
// No dependencies; imported by ptnf_ctrl, ptnf_dp and pitch_to_note_fine.
package ptnf_pkg;

  localparam int unsigned ROWS        = 48;
  localparam int unsigned SLOTS       = 32;
  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned SCALE_START = 32'h1000;
  localparam int unsigned SCALE_MUL   = 32'h103B;
  localparam int unsigned FINE_SPAN   = 128;

  localparam int unsigned SW = 14;              // scale width, scales stay below 0x2000
  localparam int unsigned AW = 30;              // bound accumulator width (scale << 15)
  localparam int unsigned RW = $clog2(ROWS + 1);
  localparam int unsigned LW = $clog2(SLOTS);
  localparam int unsigned IW = RW + LW;         // slot index width
  localparam int unsigned FW = $clog2(FINE_SPAN);

  localparam logic [IW-1:0] FALLBACK_INDEX = IW'(1536);
  localparam logic [31:0]   NOTE_BIAS      = 32'd144;   // 12 * 12

  typedef logic [ROWS:0][SW-1:0] scale_tab_t;

  // Scale of each row boundary, truncated at each step as the sequence runs.
  function automatic scale_tab_t build_scale_tab();
    scale_tab_t  t;
    logic [31:0] s;
    s = SCALE_START;
    for (int i = 0; i <= ROWS; i++) begin
      t[i] = SW'(s);
      s    = (s * SCALE_MUL) >> FRAC_BITS;
    end
    return t;
  endfunction

  localparam scale_tab_t SCALE_TAB = build_scale_tab();

  typedef struct packed {
    logic load;
    logic row_adv;
    logic slot_load;
    logic slot_adv;
    logic fin_found;
    logic fin_miss;
  } ptnf_cmd_t;

  typedef struct packed {
    logic row_hit;
    logic row_end;
    logic slot_hit;
  } ptnf_sts_t;

endpackage

// ----- rtl/core/pitch_to_note_fine.sv -----
// pitch_to_note_fine: top level, joins the sequencer and the datapath.
// Depends on ptnf_pkg, ptnf_ctrl and ptnf_dp.
//
// A beat is taken when start is high and busy is low. The block scans the 48
// scale rows one per cycle until the pitch falls below a row's top bound, then
// walks that row's 32 slots one per cycle; the result shows on
// out_packed_note_fine with out_valid high for one cycle, once the row scan,
// the slot walk and the output state are done (a pitch that misses every row
// skips the slot walk and strobes after the last row). busy stays high until
// the strobe cycle is over, so the next beat can be taken the cycle after
// out_valid. The receiver cannot stall and must take each strobed result.
module pitch_to_note_fine import ptnf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_center_note,
  input  logic [15:0] in_center_fine,
  input  logic [15:0] in_pitch_word,
  output logic        out_valid,
  output logic [31:0] out_packed_note_fine
);

  ptnf_cmd_t cmd;
  ptnf_sts_t sts;

  ptnf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ptnf_dp u_dp (
    .clk                  (clk),
    .cmd                  (cmd),
    .in_center_note       (in_center_note),
    .in_center_fine       (in_center_fine),
    .in_pitch_word        (in_pitch_word),
    .sts                  (sts),
    .out_packed_note_fine (out_packed_note_fine)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted beat did not raise busy");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.load, cmd.fin_found, cmd.fin_miss}) <= 1)
    else $error("conflicting datapath commands");

endmodule

// ----- rtl/core/ptnf_ctrl.sv -----
// ptnf_ctrl: sequencer for the row scan and slot scan of pitch_to_note_fine.
// Depends on ptnf_pkg for the command and status structs.
module ptnf_ctrl import ptnf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ptnf_sts_t sts,
  output ptnf_cmd_t cmd,
  output logic      busy,
  output logic      out_valid
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROW  = 2'd1;
  localparam logic [1:0] ST_SLOT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        if (sts.row_hit) begin
          cmd.slot_load = 1'b1;
          state_nxt     = ST_SLOT;
        end else if (sts.row_end) begin
          cmd.fin_miss = 1'b1;
          state_nxt    = ST_OUT;
        end else begin
          cmd.row_adv = 1'b1;
        end
      end
      ST_SLOT: begin
        if (sts.slot_hit) begin
          cmd.fin_found = 1'b1;
          state_nxt     = ST_OUT;
        end else begin
          cmd.slot_adv = 1'b1;
        end
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

endmodule

// ----- rtl/core/ptnf_dp.sv -----
// ptnf_dp: datapath of pitch_to_note_fine: octave encode, row and slot bound
// walk, and the final note/fine pack. Depends on ptnf_pkg.
module ptnf_dp import ptnf_pkg::*; (
  input  logic        clk,
  input  ptnf_cmd_t   cmd,
  input  logic [15:0] in_center_note,
  input  logic [15:0] in_center_fine,
  input  logic [15:0] in_pitch_word,
  output ptnf_sts_t   sts,
  output logic [31:0] out_packed_note_fine
);

  logic [15:0]   pitch_r, cnote_r, cfine_r;
  logic [3:0]    tb_r;
  logic [RW-1:0] row_r;
  logic [LW-1:0] slot_r;
  logic [AW-1:0] acc_r, step_r;
  logic [31:0]   res_r;

  // highest set bit, bit 0 for a zero pitch
  logic [3:0] tb_in;
  always_comb begin
    tb_in = 4'd0;
    for (int b = 1; b < 16; b++) begin
      if (in_pitch_word[b]) tb_in = 4'(b);
    end
  end

  // row bounds
  logic [SW-1:0] sc0, sc1;
  logic [AW-1:0] row_floor, row_span, row_step, row_top;
  always_comb begin
    sc0       = SCALE_TAB[row_r];
    sc1       = SCALE_TAB[RW'(row_r + RW'(1))];
    row_floor = AW'(sc0) << tb_r;
    row_span  = AW'(SW'(sc1 - sc0)) << tb_r;
    row_step  = row_span >> $clog2(SLOTS);
    row_top   = row_floor + (row_step << $clog2(SLOTS));
  end

  // pitch widened to the bound width for the compares
  logic [AW-1:0] pitch_x;
  assign pitch_x = {{(AW-16){1'b0}}, pitch_r};

  // slot bounds: acc_r is the lower edge of the current slot
  logic [AW-1:0] slot_hi;
  logic          slot_lo_ok;
  assign slot_hi    = acc_r + step_r;
  assign slot_lo_ok = pitch_x >= (acc_r >> FRAC_BITS);

  assign sts.row_hit  = pitch_x < (row_top >> FRAC_BITS);
  assign sts.row_end  = (row_r == RW'(ROWS - 1));
  assign sts.slot_hit = (pitch_x < (slot_hi >> FRAC_BITS))
                        || (slot_r == LW'(SLOTS - 1));

  // result pack
  logic [IW-1:0] idx;
  logic [31:0]   note;
  logic [16:0]   fine;
  always_comb begin
    if (cmd.fin_found && slot_lo_ok) idx = {row_r, slot_r};
    else                             idx = FALLBACK_INDEX;
    note = 32'(cnote_r) + 32'(idx[IW-1:FW]) + (32'(tb_r) << 3) + (32'(tb_r) << 2)
           - NOTE_BIAS;
    fine = 17'(cfine_r) + 17'(idx[FW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pitch_r <= in_pitch_word;
      cnote_r <= in_center_note;
      cfine_r <= in_center_fine;
      tb_r    <= tb_in;
      row_r   <= '0;
    end
    if (cmd.row_adv) row_r <= RW'(row_r + RW'(1));
    if (cmd.slot_load) begin
      acc_r  <= row_floor;
      step_r <= row_step;
      slot_r <= '0;
    end
    if (cmd.slot_adv) begin
      acc_r  <= slot_hi;
      slot_r <= LW'(slot_r + LW'(1));
    end
    if (cmd.fin_found || cmd.fin_miss) begin
      res_r <= {note[23:0], 8'd0} | 32'(fine);
    end
  end

  assign out_packed_note_fine = res_r;

endmodule
